@@ src/matrix4_vector_transform_assert.svh @@
// assertion macros shared by the matrix transform checker
`ifndef MATRIX4_VECTOR_TRANSFORM_ASSERT_SVH
`define MATRIX4_VECTOR_TRANSFORM_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define M4VT_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define M4VT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ src/m4vt_pkg.sv @@
// ----------------------------------------------------------------------------
// m4vt_pkg
// Types and constants for the 4x4 fixed-point matrix vector transform.
// ----------------------------------------------------------------------------
`default_nettype none

package m4vt_pkg;

    localparam int COMP_W        = 32;
    localparam int PROD_W        = 2 * COMP_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int VEC_N         = 4;
    localparam int CFG_N         = 8;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [CFG_W-1:0]         cfg_t;

    localparam comp_t COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam comp_t COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    // identity matrix, column major, two rows per register
    localparam cfg_t CFG_RESET [CFG_N] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } lane_ctrl_t;

endpackage

`default_nettype wire

@@ src/m4vt_lane.sv @@
// ----------------------------------------------------------------------------
// m4vt_lane
// One output row: four products, pairwise sum, round, shift and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module m4vt_lane
    import m4vt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire lane_ctrl_t ctrl,
    input  wire comp_t      elem [VEC_N],
    input  wire comp_t      vec  [VEC_N],
    output comp_t           res,
    output logic            sat
);

    localparam sum_t RND = sum_t'(1) << (FRAC_BITS - 1);

    prod_t prod_reg  [VEC_N];
    prod_t prod_next [VEC_N];
    sum_t  pair_reg  [2];
    sum_t  pair_next [2];
    sum_t  total;
    sum_t  shifted;
    logic  in_range;

    always_comb
    begin
        for (int c = 0; c < VEC_N; c++)
        begin
            prod_next[c] = elem[c] * vec[c];
        end
        pair_next[0] = sum_t'(prod_reg[0]) + sum_t'(prod_reg[1]);
        pair_next[1] = sum_t'(prod_reg[2]) + sum_t'(prod_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.load_sum)
        begin
            pair_reg <= pair_next;
        end
    end

    // round half up, then floor shift
    always_comb
    begin
        total    = pair_reg[0] + pair_reg[1] + RND;
        shifted  = total >>> FRAC_BITS;
        in_range = (&shifted[SUM_W-1:COMP_W-1]) | ~(|shifted[SUM_W-1:COMP_W-1]);
        sat      = ~in_range;
        if (in_range)
        begin
            res = shifted[COMP_W-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            res = COMP_MIN;
        end
        else
        begin
            res = COMP_MAX;
        end
    end

endmodule

`default_nettype wire

@@ src/m4vt_merge.sv @@
// ----------------------------------------------------------------------------
// m4vt_merge
// Output register: gathers the four lane results and merges saturation flags.
// ----------------------------------------------------------------------------
`default_nettype none

module m4vt_merge
    import m4vt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s2_valid,
    input  wire logic  out_ready,
    input  wire comp_t lane_res [VEC_N],
    input  wire logic  lane_sat [VEC_N],
    output logic       out_load,
    output logic       out_valid,
    output comp_t      out_x,
    output comp_t      out_y,
    output comp_t      out_z,
    output comp_t      out_w,
    output logic       clipped
);

    logic  out_valid_reg;
    logic  out_valid_next;
    comp_t res_reg [VEC_N];
    logic  clip_reg;
    logic  clip_next;

    always_comb
    begin
        out_load  = s2_valid & (~out_valid_reg | out_ready);
        clip_next = lane_sat[0] | lane_sat[1] | lane_sat[2] | lane_sat[3];
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg  <= lane_res;
            clip_reg <= clip_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign out_w     = res_reg[3];
    assign clipped   = clip_reg;

endmodule

`default_nettype wire

@@ src/matrix4_vector_transform.sv @@
// Pipeline: the product register loads at the accepting edge, then the pair-sum
// register, then round/saturate into the output register, which raises out_valid.
// Throughput: one vector per cycle while out_ready is high; four row lanes of four 32x32 multipliers.
// in_ready stays high while the output register can drain or a stage is empty.
// Reset (rst_n low, asynchronous): pipeline empties, matrix returns to identity.
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// Q16.16 4x4 column-major matrix times 4-component vector, saturated output.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_vector_transform
    import m4vt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire cfg_t                 cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire comp_t                in_x,
    input  wire comp_t                in_y,
    input  wire comp_t                in_z,
    input  wire comp_t                in_w,
    input  wire logic                 affine_point,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output comp_t                     out_x,
    output comp_t                     out_y,
    output comp_t                     out_z,
    output comp_t                     out_w,
    output logic                      clipped
);

    localparam comp_t W_ONE = comp_t'(1) << FRAC_BITS;

    cfg_t       cfg_reg [CFG_N];
    logic       v1_reg;
    logic       v1_next;
    logic       v2_reg;
    logic       v2_next;
    logic       adv1;
    logic       adv2;
    logic       out_load;
    lane_ctrl_t ctrl;
    comp_t      vec      [VEC_N];
    comp_t      lane_res [VEC_N];
    logic       lane_sat [VEC_N];

    // matrix registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // pipeline occupancy, bubbles collapse
    always_comb
    begin
        adv2     = v1_reg & (~v2_reg | out_load);
        in_ready = ~v1_reg | adv2;
        adv1     = in_valid & in_ready;
        if (adv1)
        begin
            v1_next = 1'b1;
        end
        else if (adv2)
        begin
            v1_next = 1'b0;
        end
        else
        begin
            v1_next = v1_reg;
        end
        if (adv2)
        begin
            v2_next = 1'b1;
        end
        else if (out_load)
        begin
            v2_next = 1'b0;
        end
        else
        begin
            v2_next = v2_reg;
        end
        ctrl.load_prod = adv1;
        ctrl.load_sum  = adv2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    assign vec[0] = in_x;
    assign vec[1] = in_y;
    assign vec[2] = in_z;
    assign vec[3] = affine_point ? W_ONE : in_w;

    for (genvar r = 0; r < VEC_N; r++)
    begin : g_lane
        comp_t elem [VEC_N];

        // column c, row r sits in register 2c + r/2, half r%2
        for (genvar c = 0; c < VEC_N; c++)
        begin : g_elem
            assign elem[c] = cfg_reg[2*c + r/2][(r%2)*COMP_W +: COMP_W];
        end

        m4vt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .elem (elem),
            .vec  (vec),
            .res  (lane_res[r]),
            .sat  (lane_sat[r])
        );
    end

    m4vt_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (v2_reg),
        .out_ready (out_ready),
        .lane_res  (lane_res),
        .lane_sat  (lane_sat),
        .out_load  (out_load),
        .out_valid (out_valid),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w),
        .clipped   (clipped)
    );

endmodule

`default_nettype wire

@@ src/m4vt_checker.sv @@
// ----------------------------------------------------------------------------
// m4vt_checker
// Port-level checks on the matrix transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix4_vector_transform_assert.svh"

module m4vt_checker
    import m4vt_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  cfg_valid,
    input wire logic  cfg_ready,
    input wire logic  in_ready,
    input wire logic  out_valid,
    input wire logic  out_ready,
    input wire comp_t out_x,
    input wire comp_t out_y,
    input wire comp_t out_z,
    input wire comp_t out_w,
    input wire logic  clipped
);

    logic any_rail;

    assign any_rail = (out_x == COMP_MAX) || (out_x == COMP_MIN) ||
                      (out_y == COMP_MAX) || (out_y == COMP_MIN) ||
                      (out_z == COMP_MAX) || (out_z == COMP_MIN) ||
                      (out_w == COMP_MAX) || (out_w == COMP_MIN);

    // matrix writes never stall
    `M4VT_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready, "cfg write stalled")

    // an empty output register means the pipeline can always take a transaction
    `M4VT_ASSERT_NOW(a_ready_when_out_empty, !out_valid, in_ready, "in_ready low with output empty")

    // saturation flag only with a component pinned at a rail
    `M4VT_ASSERT_NOW(a_clip_on_rail, out_valid && clipped, any_rail, "clipped without rail value")

    // stalled result holds
    `M4VT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) &&
        $stable(out_w) && $stable(clipped), "stalled result changed")

endmodule

bind matrix4_vector_transform m4vt_checker u_m4vt_checker (.*);

`default_nettype wire
